// ===== design/crf_pkg.sv =====
// ----------------------------------------------------------------------------
// crf_pkg
// Shared types, constants and score arithmetic for the CRF likelihood block.
// ----------------------------------------------------------------------------
package crf_pkg;

    localparam int TAG_COUNT       = 4;
    localparam int LSE_TABLE_DEPTH = 256;
    localparam int EMIT_FIELDS     = 4;
    localparam int TAG_W           = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
    localparam int HALF            = (TAG_COUNT + 1) / 2;
    localparam int RED_LEVELS      = (HALF > 1) ? $clog2(HALF) : 0;
    localparam int LSE_IDX_W       = $clog2(LSE_TABLE_DEPTH);
    localparam int LSE_PROD_W      = 16 + LSE_IDX_W + 1;

    typedef logic [TAG_W-1:0]       tag_t;
    typedef logic signed [15:0]     coef_t;
    typedef logic signed [31:0]     score_t;
    typedef score_t [TAG_COUNT-1:0] score_vec_t;
    typedef score_t [HALF-1:0]      half_vec_t;
    typedef coef_t [TAG_COUNT-1:0]  coef_vec_t;
    typedef logic [15:0]            lse_tab_t [LSE_TABLE_DEPTH];

    typedef enum logic {
        OP_LOAD,
        OP_STEP
    } crf_op_t;

    typedef struct packed {
        score_t val;
        logic   sat;
    } lse_res_t;

    typedef struct packed {
        half_vec_t v;
        logic      sat;
    } half_res_t;

    typedef struct packed {
        logic load_en;
        tag_t load_row;
        logic first_load;
        logic capture;
        logic commit;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_TREE,
        ST_OUT
    } crf_state_t;

    // shift-subtract quotient, used only while building the table
    function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
        longint unsigned q, r;
        q = 0;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // log(1 + exp(-k*16/depth)) in q12, integer series in q30
    function automatic lse_tab_t build_lse_table();
        lse_tab_t          t;
        longint unsigned   y, term, pos, neg, v, u, z, z2, acc, q1;
        q1 = 64'd1 << 30;
        for (int k = 0; k < LSE_TABLE_DEPTH; k++)
        begin
            y    = udiv64(longint'(k) << 30, 64'(LSE_TABLE_DEPTH));
            term = q1;
            pos  = q1;
            neg  = 0;
            acc  = 0;
            for (int n = 1; n <= 24; n++)
            begin
                term = udiv64((term * y) >> 30, 64'(n));
                if ((n & 1) == 1)
                    neg = neg + term;
                else
                    pos = pos + term;
            end
            v = (pos > neg) ? pos - neg : 64'd0;
            for (int n = 0; n < 4; n++)
                v = (v * v) >> 30;
            u    = v;
            z    = udiv64(u << 30, 2 * q1 + u);
            z2   = (z * z) >> 30;
            term = z;
            for (int n = 0; n < 16; n++)
            begin
                acc  = acc + udiv64(term, 64'(2 * n + 1));
                term = (term * z2) >> 30;
            end
            t[k] = 16'((2 * acc + (64'd1 << 17)) >> 18);
        end
        return t;
    endfunction

    localparam lse_tab_t LSE_TABLE = build_lse_table();

    function automatic lse_res_t sat32(logic signed [34:0] x);
        lse_res_t r;
        r.sat = 1'b0;
        if (x > 35'sd2147483647)
        begin
            r.val = 32'sh7fffffff;
            r.sat = 1'b1;
        end
        else if (x < -35'sd2147483648)
        begin
            r.val = 32'sh80000000;
            r.sat = 1'b1;
        end
        else
            r.val = x[31:0];
        return r;
    endfunction

    function automatic lse_res_t lse2(score_t a, score_t b);
        score_t                  mx, mn;
        logic [32:0]             d;
        logic [LSE_PROD_W-1:0]   prod;
        logic [LSE_IDX_W-1:0]    idx;
        logic [15:0]             corr;
        mx   = ($signed(a) > $signed(b)) ? a : b;
        mn   = ($signed(a) > $signed(b)) ? b : a;
        d    = 33'($signed({mx[31], mx}) - $signed({mn[31], mn}));
        prod = LSE_PROD_W'(d[15:0]) * LSE_PROD_W'(LSE_TABLE_DEPTH);
        idx  = prod[16 +: LSE_IDX_W];
        corr = (d < 33'd65536) ? LSE_TABLE[idx] : 16'd0;
        return sat32(35'($signed(mx)) + 35'($signed({1'b0, corr})));
    endfunction

    function automatic half_res_t lse_level1(score_vec_t a);
        half_res_t r;
        lse_res_t  p;
        r.sat = 1'b0;
        for (int i = 0; i < HALF; i++)
        begin
            if (2 * i + 1 < TAG_COUNT)
            begin
                p      = lse2(a[2 * i], a[2 * i + 1]);
                r.v[i] = p.val;
                r.sat  = r.sat | p.sat;
            end
            else
                r.v[i] = a[2 * i];
        end
        return r;
    endfunction

    function automatic lse_res_t lse_reduce(half_vec_t h);
        score_t   v [2 * HALF];
        score_t   t [2 * HALF];
        int       n;
        lse_res_t p;
        lse_res_t r;
        for (int i = 0; i < 2 * HALF; i++)
            v[i] = (i < HALF) ? h[i] : '0;
        n     = HALF;
        r.sat = 1'b0;
        for (int lvl = 0; lvl < RED_LEVELS; lvl++)
        begin
            for (int i = 0; i < 2 * HALF; i++)
                t[i] = v[i];
            for (int i = 0; i < HALF; i++)
            begin
                if (i < (n >> 1))
                begin
                    p     = lse2(v[2 * i], v[2 * i + 1]);
                    t[i]  = p.val;
                    r.sat = r.sat | p.sat;
                end
                else if (i == (n >> 1) && (n & 1) == 1)
                    t[i] = v[n - 1];
            end
            for (int i = 0; i < 2 * HALF; i++)
                v[i] = t[i];
            n = (n + 1) >> 1;
        end
        r.val = v[0];
        return r;
    endfunction

endpackage

// ===== design/crf_cell.sv =====
// ----------------------------------------------------------------------------
// crf_cell
// One destination tag: its forward score, its transition column and a
// log-sum-exp over all source tags, its first level held in half_reg.
// ----------------------------------------------------------------------------
module crf_cell
    import crf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  coef_t      trans_value,
    input  coef_t      emit,
    input  score_vec_t fwd_all,
    input  tag_t       prev_tag,
    output score_t     fwd,
    output coef_t      trans_prev,
    output logic       sat
);

    coef_t      trans_reg [TAG_COUNT];
    score_t     fwd_reg;
    score_t     fwd_next;
    half_vec_t  half_reg;
    score_vec_t work;
    logic       work_sat;
    half_res_t  lvl1;
    lse_res_t   red;
    lse_res_t   s;

    always_comb
    begin
        work_sat = 1'b0;
        for (int i = 0; i < TAG_COUNT; i++)
        begin
            s        = sat32(35'($signed(fwd_all[i])) + 35'($signed(trans_reg[i]))
                             + 35'($signed(emit)));
            work[i]  = s.val;
            work_sat = work_sat | s.sat;
        end
        lvl1 = lse_level1(work);
        red  = lse_reduce(half_reg);
    end

    always_comb
    begin
        fwd_next = fwd_reg;
        if (ctl.first_load)
            fwd_next = score_t'(emit);
        else if (ctl.commit)
            fwd_next = red.val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= '0;
        else
            fwd_reg <= fwd_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_en)
            trans_reg[ctl.load_row] <= trans_value;
        if (ctl.capture)
            half_reg <= lvl1.v;
    end

    assign fwd        = fwd_reg;
    assign trans_prev = trans_reg[prev_tag];
    assign sat        = (ctl.capture & (work_sat | lvl1.sat)) | (ctl.commit & red.sat);

endmodule

// ===== design/crf_sequence_log_likelihood.sv =====
// ----------------------------------------------------------------------------
// crf_sequence_log_likelihood
// Linear-chain CRF log-likelihood of one sequence, forward scores kept in a
// row of per-tag cells.
// ----------------------------------------------------------------------------
// A load request (opcode 0) writes one transition entry and leaves the input
// free. A step request (opcode 1) forms, in the cycle it is accepted, every
// source-plus-transition-plus-emission sum and the first level of the
// pairwise log-sum-exp tree in each cell; the next cycle finishes the tree
// and updates the forward and gold scores. A step marked last then passes
// through ST_TREE (first tree level of the forward scores) and ST_OUT, which
// ends the tree and loads the result register once out_stall lets it. Scores
// are Q20.12 and saturate; saturated flags any saturation since the first step.
// ----------------------------------------------------------------------------
module crf_sequence_log_likelihood
    import crf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [1:0]         from_tag,
    input  logic [1:0]         to_tag,
    input  logic signed [15:0] trans_value,
    input  logic [1:0]         gold_tag,
    input  logic               step_mask,
    input  logic               first_step,
    input  logic               last_step,
    input  logic signed [15:0] emit_tag0,
    input  logic signed [15:0] emit_tag1,
    input  logic signed [15:0] emit_tag2,
    input  logic signed [15:0] emit_tag3,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] log_likelihood,
    output logic               saturated
);

    crf_state_t state_reg, state_next;
    score_t     gold_score_reg, gold_score_next;
    tag_t       prev_tag_reg, prev_tag_next;
    tag_t       gold_reg;
    coef_t      emit_gold_reg;
    logic       upd_reg, last_reg;
    logic       flag_reg, flag_next;
    half_vec_t  tree_half_reg;
    logic       out_valid_reg, out_valid_next;
    score_t     ll_reg;
    logic       sat_out_reg;

    coef_vec_t  emit_vec;
    score_vec_t fwd_all;
    coef_vec_t  trans_prev_all;
    logic [TAG_COUNT-1:0] cell_sat;
    cell_ctl_t  ctl [TAG_COUNT];

    logic       accept, step_acc, load_ok, out_free;
    tag_t       gold_in, load_row, load_col;
    half_res_t  tree1;
    lse_res_t   tree2, gsum, diff;

    always_comb
    begin
        emit_vec = '0;
        for (int j = 0; j < TAG_COUNT && j < EMIT_FIELDS; j++)
        begin
            unique case (j)
                0:       emit_vec[j] = emit_tag0;
                1:       emit_vec[j] = emit_tag1;
                2:       emit_vec[j] = emit_tag2;
                default: emit_vec[j] = emit_tag3;
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid & ~in_stall;
    assign step_acc = accept & (opcode == OP_STEP);
    assign gold_in  = (int'(gold_tag) >= TAG_COUNT) ? tag_t'(TAG_COUNT - 1) : tag_t'(gold_tag);
    assign load_ok  = accept & (opcode == OP_LOAD) & (int'(from_tag) < TAG_COUNT)
                      & (int'(to_tag) < TAG_COUNT);
    assign load_row = tag_t'(from_tag);
    assign load_col = tag_t'(to_tag);
    assign out_free = ~out_valid_reg | ~out_stall;

    genvar g;
    generate
        for (g = 0; g < TAG_COUNT; g++)
        begin : g_cell
            always_comb
            begin
                ctl[g].load_en    = load_ok & (load_col == tag_t'(g));
                ctl[g].load_row   = load_row;
                ctl[g].first_load = step_acc & first_step;
                ctl[g].capture    = step_acc & ~first_step & step_mask;
                ctl[g].commit     = (state_reg == ST_STEP) & upd_reg;
            end

            crf_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl[g]),
                .trans_value (trans_value),
                .emit        (emit_vec[g]),
                .fwd_all     (fwd_all),
                .prev_tag    (prev_tag_reg),
                .fwd         (fwd_all[g]),
                .trans_prev  (trans_prev_all[g]),
                .sat         (cell_sat[g])
            );
        end
    endgenerate

    always_comb
    begin
        tree1 = lse_level1(fwd_all);
        tree2 = lse_reduce(tree_half_reg);
        gsum  = sat32(35'($signed(gold_score_reg)) + 35'($signed(trans_prev_all[gold_reg]))
                      + 35'($signed(emit_gold_reg)));
        diff  = sat32(35'($signed(gold_score_reg)) - 35'($signed(tree2.val)));
    end

    always_comb
    begin
        state_next      = state_reg;
        gold_score_next = gold_score_reg;
        prev_tag_next   = prev_tag_reg;
        flag_next       = flag_reg | (|cell_sat);
        out_valid_next  = out_valid_reg & out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (step_acc)
                begin
                    state_next = ST_STEP;
                    if (first_step)
                    begin
                        gold_score_next = score_t'(emit_vec[gold_in]);
                        flag_next       = 1'b0;
                    end
                end
            end
            ST_STEP:
            begin
                prev_tag_next = gold_reg;
                if (upd_reg)
                begin
                    gold_score_next = gsum.val;
                    flag_next       = flag_next | gsum.sat;
                end
                state_next = last_reg ? ST_TREE : ST_IDLE;
            end
            ST_TREE:
            begin
                flag_next  = flag_next | tree1.sat;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    flag_next      = flag_next | tree2.sat | diff.sat;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            gold_score_reg <= '0;
            prev_tag_reg   <= '0;
            flag_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            upd_reg        <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            gold_score_reg <= gold_score_next;
            prev_tag_reg   <= prev_tag_next;
            flag_reg       <= flag_next;
            out_valid_reg  <= out_valid_next;
            if (step_acc)
            begin
                upd_reg  <= ~first_step & step_mask;
                last_reg <= last_step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_acc)
        begin
            gold_reg      <= gold_in;
            emit_gold_reg <= emit_vec[gold_in];
        end
        if (state_reg == ST_TREE)
            tree_half_reg <= tree1.v;
        if (state_reg == ST_OUT && out_free)
        begin
            ll_reg      <= diff.val;
            sat_out_reg <= flag_reg | tree2.sat | diff.sat;
        end
    end

    assign out_valid      = out_valid_reg;
    assign log_likelihood = ll_reg;
    assign saturated      = sat_out_reg;

endmodule

// ===== design/crf_checker.sv =====
// ----------------------------------------------------------------------------
// crf_checker
// Port-level checks on request pacing and result holding.
// ----------------------------------------------------------------------------
module crf_checker
    import crf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               opcode,
    input logic               last_step,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] log_likelihood,
    input logic               saturated
);

    // a load request never holds off the next request
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == OP_LOAD) |=> !in_stall)
        else $error("stall after load request");

    // a step request occupies the next cycle
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == OP_STEP) |=> in_stall)
        else $error("no stall after step request");

    // a non-final step frees the input once its ST_STEP state is over
    a_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == OP_STEP) && !last_step |=> ##1 !in_stall)
        else $error("non-final step held input too long");

    // held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(log_likelihood) && $stable(saturated))
        else $error("stalled result changed");

endmodule

bind crf_sequence_log_likelihood crf_checker u_crf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .last_step      (last_step),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .log_likelihood (log_likelihood),
    .saturated      (saturated)
);

// ===== dv/tb_crf_sequence_log_likelihood.sv =====
// ----------------------------------------------------------------------------
// tb_crf_sequence_log_likelihood
// Self-checking bench for the CRF log-likelihood block. A driver feeds the
// transition loads and sequence steps from a queue. An independent
// fixed-point predictor produces the expected likelihood and saturation flag
// for each last step. A monitor compares every result in order. The run goes
// through phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_crf_sequence_log_likelihood;
    import crf_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        bit               op;
        bit [1:0]         src;
        bit [1:0]         dst;
        bit signed [15:0] tv;
        bit [1:0]         gold;
        bit               mask;
        bit               first;
        bit               last;
        bit signed [15:0] em [4];
    } crf_req_t;

    typedef struct {
        bit signed [31:0] ll;
        bit               sat;
    } ll_res_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic opcode, step_mask, first_step, last_step;
    logic [1:0] from_tag, to_tag, gold_tag;
    logic signed [15:0] trans_value, emit_tag0, emit_tag1, emit_tag2, emit_tag3;
    logic signed [31:0] log_likelihood;
    logic saturated;

    crf_sequence_log_likelihood uut (.*);

    crf_req_t pending_reqs [$];
    ll_res_t  expected_ll [$];
    int       errors = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       idle_cycles = 0;
    int       gold_pause = 0;

    // predictor state
    int unsigned lse_corr [256];
    bit signed [31:0] p_trans [16];
    bit signed [31:0] p_fwd [4];
    bit signed [31:0] p_gold;
    bit [1:0]         p_prev;
    bit               p_sat;

    function automatic void make_lse_corr();
        longint unsigned y, term, pos, neg, v, u, z, z2, acc, one;
        one = 64'd1 << 30;
        for (int k = 0; k < 256; k++)
        begin
            y = (longint'(k) << 30) / 256;
            term = one; pos = one; neg = 0; acc = 0;
            for (int n = 1; n <= 24; n++)
            begin
                term = ((term * y) >> 30) / n;
                if (n & 1) neg += term; else pos += term;
            end
            v = pos > neg ? pos - neg : 0;
            for (int n = 0; n < 4; n++) v = (v * v) >> 30;
            u = v;
            z = (u << 30) / (2 * one + u);
            z2 = (z * z) >> 30;
            term = z;
            for (int n = 0; n < 16; n++)
            begin
                acc += term / (2 * n + 1);
                term = (term * z2) >> 30;
            end
            lse_corr[k] = (2 * acc + (64'd1 << 17)) >> 18;
        end
    endfunction

    function automatic bit signed [31:0] clamp32(longint x);
        if (x > 64'sd2147483647)
        begin
            p_sat = 1;
            return 32'sh7fffffff;
        end
        if (x < -64'sd2147483648)
        begin
            p_sat = 1;
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic bit signed [31:0] log_add(bit signed [31:0] a, bit signed [31:0] b);
        longint mx, mn, d, c;
        mx = a > b ? a : b;
        mn = a > b ? b : a;
        d = mx - mn;
        c = d < 65536 ? lse_corr[(d * 256) >> 16] : 0;
        return clamp32(mx + c);
    endfunction

    function automatic bit signed [31:0] log_sum4(bit signed [31:0] v [4]);
        return log_add(log_add(v[0], v[1]), log_add(v[2], v[3]));
    endfunction

    function automatic void predict_step(crf_req_t r);
        bit signed [31:0] w [4];
        bit signed [31:0] nxt [4];
        bit signed [31:0] z;
        ll_res_t res;
        if (r.op == OP_LOAD)
        begin
            p_trans[r.src * 4 + r.dst] = r.tv;
            return;
        end
        if (r.first)
        begin
            for (int j = 0; j < 4; j++) p_fwd[j] = r.em[j];
            p_sat = 0;
            p_gold = r.em[r.gold];
        end
        else if (r.mask)
        begin
            for (int j = 0; j < 4; j++)
            begin
                for (int i = 0; i < 4; i++)
                    w[i] = clamp32(longint'(p_fwd[i]) + p_trans[i * 4 + j] + r.em[j]);
                nxt[j] = log_sum4(w);
            end
            p_fwd = nxt;
            p_gold = clamp32(longint'(p_gold) + p_trans[p_prev * 4 + r.gold] + r.em[r.gold]);
        end
        p_prev = r.gold;
        if (r.last)
        begin
            z = log_sum4(p_fwd);
            res.ll = clamp32(longint'(p_gold) - z);
            res.sat = p_sat;
            expected_ll.insert(expected_ll.size(), res);
        end
    endfunction

    function automatic bit signed [15:0] rand_coef(int kind);
        case (kind)
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 8191)) - 16'sd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_load(bit [1:0] s, bit [1:0] d, bit signed [15:0] v);
        crf_req_t r;
        r = '{default: '0};
        r.op = OP_LOAD;
        r.src = s; r.dst = d; r.tv = v;
        r.gold = 2'($urandom); r.mask = 1'($urandom);
        r.first = 1'($urandom); r.last = 1'($urandom);
        for (int j = 0; j < 4; j++) r.em[j] = 16'($urandom);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic void add_step(bit f, bit l, bit m, int kind);
        crf_req_t r;
        r = '{default: '0};
        r.op = OP_STEP;
        r.src = 2'($urandom); r.dst = 2'($urandom); r.tv = 16'($urandom);
        r.gold = 2'($urandom);
        r.first = f; r.last = l; r.mask = m;
        for (int j = 0; j < 4; j++) r.em[j] = rand_coef(kind < 0 ? $urandom_range(0, 4) : kind);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic void add_sequence(int len, int kind);
        for (int t = 0; t < len; t++)
            add_step(t == 0, t == len - 1, $urandom_range(0, 5) != 0, kind);
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            opcode <= 0; from_tag <= 0; to_tag <= 0; trans_value <= 0;
            gold_tag <= 0; step_mask <= 0; first_step <= 0; last_step <= 0;
            emit_tag0 <= 0; emit_tag1 <= 0; emit_tag2 <= 0; emit_tag3 <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(1, 100) > send_idle_pct &&
                !(gold_pause > 0 && expected_ll.size() > 0))
            begin
                crf_req_t r;
                r = pending_reqs.pop_front();
                predict_step(r);
                if (gold_pause > 0) gold_pause <= gold_pause - 1;
                in_valid <= 1;
                opcode <= r.op; from_tag <= r.src; to_tag <= r.dst; trans_value <= r.tv;
                gold_tag <= r.gold; step_mask <= r.mask;
                first_step <= r.first; last_step <= r.last;
                emit_tag0 <= r.em[0]; emit_tag1 <= r.em[1];
                emit_tag2 <= r.em[2]; emit_tag3 <= r.em[3];
            end
            else
                in_valid <= 0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_ll.size() == 0)
                begin
                    $error("unexpected result log_likelihood=%0d", log_likelihood);
                    errors++;
                end
                else
                begin
                    ll_res_t e;
                    e = expected_ll.pop_front();
                    if (log_likelihood !== e.ll)
                    begin
                        $error("log_likelihood expected %0d actual %0d", e.ll, log_likelihood);
                        errors++;
                    end
                    if (saturated !== e.sat)
                    begin
                        $error("saturated expected %0d actual %0d", e.sat, saturated);
                        errors++;
                    end
                end
            end
            out_stall <= $urandom_range(1, 100) <= recv_stall_pct;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int total;
        make_lse_corr();
        p_fwd = '{default: 0};
        p_gold = 0; p_prev = 0; p_sat = 0;
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;

        // directed: full table at extremes and zero, then special cases
        for (int i = 0; i < 16; i++)
            add_load(i / 4, i % 4, i % 3 == 0 ? 16'sh7fff : (i % 3 == 1 ? 16'sh8000 : 16'sd0));
        add_step(1, 1, 0, 0);
        add_step(1, 0, 1, 0);
        add_step(0, 0, 0, 1);
        add_step(0, 1, 1, 1);
        add_step(0, 1, 1, 3);
        add_step(1, 0, 1, 2);
        add_step(0, 1, 1, 2);

        for (int n = 0; n < 450;)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_load(2'($urandom), 2'($urandom), rand_coef($urandom_range(0, 4)));
                n++;
            end
            else
            begin
                int len;
                len = $urandom_range(1, 8);
                add_sequence(len, $urandom_range(0, 3) == 0 ? -1 : 2);
                if ($urandom_range(0, 15) == 0)
                    add_step(0, $urandom_range(0, 1), 1'($urandom), -1);
                n += len;
            end
        end

        total = pending_reqs.size();
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; gold_pause = 40; end
            endcase
            wait (pending_reqs.size() <= total * (3 - phase) / 4);
        end
        wait (pending_reqs.size() == 0);
        @(posedge clk iff (!in_valid || !in_stall));
        @(posedge clk);
        wait (expected_ll.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== crf_sequence_log_likelihood.f =====
design/crf_pkg.sv
design/crf_cell.sv
design/crf_sequence_log_likelihood.sv
design/crf_checker.sv
dv/tb_crf_sequence_log_likelihood.sv
